[design/asf_pkg.sv]
// Shared types and constants for the audio sample FIFO.
// Self-contained; imported by every other file of the block.
package asf_pkg;

  localparam int DEFAULT_SLOT_COUNT = 7;
  localparam int DATA_W = 32;
  localparam int SAMPLE_W = 16;
  localparam int FILL_W = 3;
  localparam int THRESH_W = 3;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 3'd3;

  typedef enum logic [1:0] {
    ACT_PUSH_BYTES = 2'd0,
    ACT_PUSH_HALF  = 2'd1,
    ACT_POP        = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [DATA_W-1:0]   packed_data;
  } asf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       refill_request;
    logic [DATA_W-1:0]          tail_word;
    logic [FILL_W-1:0]          fill_level;
  } asf_out_t;

  // Both words of one slot: high bytes and low bytes of four lanes.
  typedef struct packed {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } slot_words_t;

  // Per-item result fields worked out by the control unit.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       refill_request;
    logic [FILL_W-1:0]          fill_level;
  } step_result_t;

endpackage

[design/asf_store.sv]
// Slot storage of the audio sample FIFO: two 32-bit words per slot.
// Depends on asf_pkg. One write port, two registered read ports with write forwarding.
module asf_store #(
  parameter int SLOT_COUNT = asf_pkg::DEFAULT_SLOT_COUNT,
  parameter int IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  asf_pkg::slot_words_t      wr_words,
  input  logic [IDX_W-1:0]          rd_addr_a,
  input  logic [IDX_W-1:0]          rd_addr_b,
  output asf_pkg::slot_words_t      rd_a,
  output asf_pkg::slot_words_t      rd_b
);
  import asf_pkg::*;

  logic [DATA_W-1:0] hi_mem [SLOT_COUNT];
  logic [DATA_W-1:0] lo_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hi_mem[wr_addr] <= wr_words.hi;
      lo_mem[wr_addr] <= wr_words.lo;
    end
  end

  // A slot never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_a <= '0;
      rd_b <= '0;
    end else begin
      if (wr_en && (wr_addr == rd_addr_a)) begin
        rd_a <= wr_words;
      end else if (slot_valid[rd_addr_a]) begin
        rd_a <= '{hi: hi_mem[rd_addr_a], lo: lo_mem[rd_addr_a]};
      end else begin
        rd_a <= '0;
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
        rd_b <= wr_words;
      end else if (slot_valid[rd_addr_b]) begin
        rd_b <= '{hi: hi_mem[rd_addr_b], lo: lo_mem[rd_addr_b]};
      end else begin
        rd_b <= '0;
      end
    end
  end

endmodule

[design/asf_ctrl.sv]
// Pointer state and per-item step logic of the audio sample FIFO.
// Depends on asf_pkg; works on the registered slot words from asf_store.
module asf_ctrl #(
  parameter int SLOT_COUNT = asf_pkg::DEFAULT_SLOT_COUNT,
  parameter int IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  asf_pkg::asf_in_t               item,
  input  logic [asf_pkg::THRESH_W-1:0]   threshold,
  input  asf_pkg::slot_words_t           rd_head,
  input  asf_pkg::slot_words_t           rd_tail,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_addr,
  output asf_pkg::slot_words_t           wr_words,
  output logic [IDX_W-1:0]               rd_addr_head,
  output logic [IDX_W-1:0]               rd_addr_tail,
  output asf_pkg::step_result_t          result
);
  import asf_pkg::*;

  localparam int OCC_W = $clog2(SLOT_COUNT + 1);
  localparam int SUM_W = OCC_W + 1;
  localparam int CMP_W = (OCC_W > THRESH_W) ? OCC_W : THRESH_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
  localparam logic [OCC_W-1:0] FULL = OCC_W'(SLOT_COUNT);

  logic [IDX_W-1:0] head, head_next;
  logic [OCC_W-1:0] occ, occ_next;
  logic [1:0]       lane, lane_next;
  logic             upper, upper_next;
  logic [15:0]      half_hi, half_lo;
  logic [7:0]       byte_hi, byte_lo;

  // Head plus count, folded back into the slot range (sum stays below twice the depth).
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [OCC_W-1:0] count);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(count);
    if (s >= SUM_W'(SLOT_COUNT)) begin
      s = s - SUM_W'(SLOT_COUNT);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [7:0] lane_byte(input logic [DATA_W-1:0] w, input logic [1:0] l);
    logic [7:0] b;
    case (l)
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      2'd3:    b = w[31:24];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      occ   <= '0;
      lane  <= '0;
      upper <= 1'b0;
    end else begin
      head  <= head_next;
      occ   <= occ_next;
      lane  <= lane_next;
      upper <= upper_next;
    end
  end

  // Halfword push: high bytes of both samples go to the high word, low bytes to the low word.
  assign half_hi = {item.packed_data[31:24], item.packed_data[15:8]};
  assign half_lo = {item.packed_data[23:16], item.packed_data[7:0]};
  assign byte_hi = lane_byte(rd_head.hi, lane);
  assign byte_lo = lane_byte(rd_head.lo, lane);

  assign wr_addr = wrap_add(head, occ);

  always_comb begin
    head_next  = head;
    occ_next   = occ;
    lane_next  = lane;
    upper_next = upper;
    wr_en      = 1'b0;
    wr_words   = rd_tail;
    result.sample = '0;
    result.refill_request = 1'b0;
    if (step) begin
      case (item.action)
        ACT_PUSH_BYTES: begin
          wr_en       = 1'b1;
          wr_words.hi = item.packed_data;
          wr_words.lo = '0;
          upper_next  = 1'b0;
          if (occ != FULL) begin
            occ_next = occ + 1'b1;
          end
        end
        ACT_PUSH_HALF: begin
          wr_en = 1'b1;
          if (upper) begin
            wr_words.hi = {rd_tail.hi[31:16], half_hi};
            wr_words.lo = {rd_tail.lo[31:16], half_lo};
            upper_next  = 1'b0;
          end else begin
            wr_words.hi = {half_hi, rd_tail.hi[15:0]};
            wr_words.lo = {half_lo, rd_tail.lo[15:0]};
            upper_next  = 1'b1;
            if (occ != FULL) begin
              occ_next = occ + 1'b1;
            end
          end
        end
        ACT_POP: begin
          if (occ == '0) begin
            result.refill_request = 1'b1;
          end else begin
            result.sample = $signed({byte_hi, byte_lo});
            lane_next = lane + 2'd1;
            if (lane == 2'd3) begin
              head_next = (head == LAST_SLOT) ? '0 : head + 1'b1;
              occ_next  = occ - 1'b1;
            end
            result.refill_request = (CMP_W'(occ_next) <= CMP_W'(threshold));
          end
        end
        ACT_CLEAR: begin
          occ_next  = '0;
          lane_next = '0;
        end
        default: begin
          occ_next = occ;
        end
      endcase
    end
    result.fill_level = FILL_W'(occ_next);
  end

  // Reads are aimed at the slots the state will point at after this edge.
  assign rd_addr_head = head_next;
  assign rd_addr_tail = wrap_add(head_next, occ_next);

endmodule

[design/audio_sample_fifo.sv]
// Top level of the audio sample FIFO: input register, result register, threshold register.
// Depends on asf_pkg, asf_store and asf_ctrl.
//
//  channel   signals                          direction  transfer when
//  ------    -------------------------------  ---------  ---------------------------
//  input     in_valid, in_stall, in_data      in         in_valid && !in_stall
//  result    out_valid, out_stall, out_data   out        out_valid && !out_stall
//  config    cfg_we, cfg_wdata                in         cfg_we (no wait)
//
// Each item is registered on its input transfer and worked when it commits, which a stalled
// result can delay; its result is written to the result register on that commit. One item
// can enter every cycle while the result is not stalled: the limit is the single
// read-modify-write of the tail slot per cycle in the slot store.
// Reset (rst, synchronous) empties the FIFO and sets the refill threshold to 3; slot
// contents read as zero until written, so no clearing pass is needed.
// A stalled result holds the item register, which in turn raises in_stall.
module audio_sample_fifo #(
  parameter int SLOT_COUNT = asf_pkg::DEFAULT_SLOT_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  asf_pkg::asf_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output asf_pkg::asf_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [asf_pkg::THRESH_W-1:0]   cfg_wdata
);
  import asf_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic [THRESH_W-1:0] threshold;
  asf_in_t             item_q;
  logic                item_valid;
  step_result_t        res_q;
  step_result_t        step_res;
  logic                commit;
  logic                in_xfer;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  slot_words_t         wr_words;
  logic [IDX_W-1:0]    rd_addr_head;
  logic [IDX_W-1:0]    rd_addr_tail;
  slot_words_t         rd_head;
  slot_words_t         rd_tail;

  // The held item commits when the result register is free or is being emptied.
  assign commit   = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !commit;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (commit) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_q <= step_res;
    end
  end

  asf_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (commit),
    .item         (item_q),
    .threshold    (threshold),
    .rd_head      (rd_head),
    .rd_tail      (rd_tail),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_words     (wr_words),
    .rd_addr_head (rd_addr_head),
    .rd_addr_tail (rd_addr_tail),
    .result       (step_res)
  );

  asf_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_words  (wr_words),
    .rd_addr_a (rd_addr_head),
    .rd_addr_b (rd_addr_tail),
    .rd_a      (rd_head),
    .rd_b      (rd_tail)
  );

  // The tail read register always holds the tail slot of the committed state, which is
  // exactly the state left by the item in the result register; it only moves on a commit.
  assign out_data.sample         = res_q.sample;
  assign out_data.refill_request = res_q.refill_request;
  assign out_data.tail_word      = rd_tail.hi;
  assign out_data.fill_level     = res_q.fill_level;

endmodule
